// File: rtl/core/bia_pkg.sv
// bia_pkg: shared types and constants of the bitmap identifier allocator
// used by bia_ffz and bitmap_id_allocator; no dependencies

package bia_pkg;

    localparam int ID_W   = 13;
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    localparam logic       OP_ALLOCATE     = 1'b0;
    localparam logic       OP_RELEASE      = 1'b1;
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED    = 2'd1;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] release_id;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic [1:0]      status;
    } t_rsp;

endpackage

// File: rtl/core/bia_ram.sv
// bia_ram: generic single-port ram with registered read
// no package dependency

module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 74
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bia_ffz.sv
// bia_ffz: lowest clear bit of one map word, byte search then bit search
// depends on bia_pkg for the word and position widths

module bia_ffz
    import bia_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    output logic [BIT_W-1:0]  o_pos
);

    localparam int BYTES = WORD_W / 8;

    logic [BYTES-1:0] byte_free;
    logic [2:0]       byte_sel;
    logic [7:0]       byte_val;
    logic [2:0]       bit_sel;

    always_comb begin
        for (int b = 0; b < BYTES; b++) begin
            byte_free[b] = ~&i_word[b*8 +: 8];
        end
        byte_sel = '0;
        for (int b = BYTES - 1; b >= 0; b--) begin
            if (byte_free[b]) begin
                byte_sel = 3'(b);
            end
        end
        byte_val = i_word[{byte_sel, 3'b000} +: 8];
        bit_sel  = '0;
        for (int k = 7; k >= 0; k--) begin
            if (!byte_val[k]) begin
                bit_sel = 3'(k);
            end
        end
        o_pos = {byte_sel, bit_sel};
    end

endmodule

// File: rtl/core/bitmap_id_allocator.sv
// bitmap_id_allocator: lowest-free identifier allocator over LOWEST_ID..HIGHEST_ID
// depends on bia_pkg, bia_ram (in-use map words) and bia_ffz (clear bit search)
//
// usage
//   input channel: i_in_valid / o_in_stall carry a t_req item (op, release_id).
//   output channel: o_out_valid / i_out_stall carry a t_rsp item (granted_id, status).
//   one result item per input item, in order.
//   the in-use map sits in a ram of 64-bit words, one read or write per cycle.
//   allocate reads one word a cycle from the lowest until a word with a clear
//   bit turns up, then sets the bit and writes the word back; it reads at most
//   ceil(id_count / 64) words, 74 with the default range; exhausted writes nothing.
//   release is a read-modify-write of one word.
//   a release outside the range answers without touching the map.
//   one item is in work at a time; o_in_stall is high until its result is
//   loaded into the output register, which may still be waiting while the
//   next item is accepted.
//   reset clears a per-word valid flag, so every identifier reads free at once;
//   there is no clearing pass.
//   a stalled result holds in the output register and the sequencer waits on it.

module bitmap_id_allocator
    import bia_pkg::*;
#(
    parameter int LOWEST_ID  = 300,
    parameter int HIGHEST_ID = 5000
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_item,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_item
);

    localparam int ID_COUNT  = (HIGHEST_ID >= LOWEST_ID) ? (HIGHEST_ID - LOWEST_ID + 1) : 0;
    localparam int WORDS     = (ID_COUNT == 0) ? 1 : (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int AW        = $clog2(WORDS > 1 ? WORDS : 2);
    localparam int LAST_BITS = (ID_COUNT == 0) ? 0 : ID_COUNT - (WORDS - 1) * WORD_W;
    localparam logic [AW-1:0]   LAST_ADDR = AW'(WORDS - 1);
    localparam logic [ID_W-1:0] LO_V      = ID_W'(LOWEST_ID);
    localparam logic [ID_W-1:0] HI_V      = ID_W'(HIGHEST_ID);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIND,
        S_WR,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic              r_op, n_op;
    logic [AW-1:0]     r_addr, n_addr;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [WORD_W-1:0] r_word, n_word;
    t_rsp              r_res, n_res;
    t_rsp              r_out, n_out;
    logic              r_out_vld, n_out_vld;
    logic [WORDS-1:0]  r_row_vld, n_row_vld;
    logic              r_rd_vld;

    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] cur_word;
    logic [WORD_W-1:0] pad_mask;
    logic [WORD_W-1:0] chk_word;
    logic [BIT_W-1:0]  ffz_pos;
    logic [ID_W-1:0]   rel_off;
    logic              rel_in_range;
    logic              in_acc;

    bia_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_addr  (n_addr),
        .i_we    (r_state == S_WR),
        .i_wdata (r_word),
        .o_rdata (ram_rdata)
    );

    bia_ffz u_ffz (
        .i_word (r_word),
        .o_pos  (ffz_pos)
    );

    // rows never written since reset read as all free
    assign cur_word = r_rd_vld ? ram_rdata : '0;

    // bits past the top identifier count as used
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            pad_mask[b] = (r_addr == LAST_ADDR) && (b >= LAST_BITS);
        end
    end
    assign chk_word = cur_word | pad_mask;

    assign rel_off      = i_in_item.release_id - LO_V;
    assign rel_in_range = (ID_COUNT > 0) && (i_in_item.release_id >= LO_V)
                          && (i_in_item.release_id <= HI_V);
    assign in_acc       = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_addr    = r_addr;
        n_bit     = r_bit;
        n_word    = r_word;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        n_row_vld = r_row_vld;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = i_in_item.op;
                    n_res = '{granted_id: '0, status: ST_OK};
                    if (i_in_item.op == OP_ALLOCATE) begin
                        if (ID_COUNT == 0) begin
                            n_res.status = ST_EXHAUSTED;
                            n_state      = S_OUT;
                        end else begin
                            n_addr  = '0;
                            n_state = S_SCAN;
                        end
                    end else if (rel_in_range) begin
                        n_addr  = rel_off[BIT_W +: AW];
                        n_bit   = rel_off[BIT_W-1:0];
                        n_state = S_SCAN;
                    end else begin
                        n_res.status = ST_OUT_OF_RANGE;
                        n_state      = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (r_op == OP_RELEASE) begin
                    n_word  = cur_word & ~(WORD_W'(1) << r_bit);
                    n_state = S_WR;
                end else if (!(&chk_word)) begin
                    n_word  = chk_word;
                    n_state = S_FIND;
                end else if (r_addr == LAST_ADDR) begin
                    n_res.status = ST_EXHAUSTED;
                    n_state      = S_OUT;
                end else begin
                    // next word is read while this one is checked
                    n_addr = r_addr + 1'b1;
                end
            end
            S_FIND: begin
                n_word           = r_word | (WORD_W'(1) << ffz_pos);
                n_res.granted_id = ID_W'({r_addr, ffz_pos}) + LO_V;
                n_state          = S_WR;
            end
            S_WR: begin
                n_row_vld[r_addr] = 1'b1;
                n_state           = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_row_vld <= n_row_vld;
            r_rd_vld  <= r_row_vld[n_addr];
        end
        r_op   <= n_op;
        r_addr <= n_addr;
        r_bit  <= n_bit;
        r_word <= n_word;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule
